// ----- hdl/csq_pkg.sv -----
// shared types and constants for the cursor sequence store
package csq_pkg;

   localparam int DEPTH       = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // fixed field widths of the channels
   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 6;
   localparam int POS_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 3'd0,
      OP_ADVANCE = 3'd1,
      OP_INSERT  = 3'd2,
      OP_ATTACH  = 3'd3,
      OP_REMOVE  = 3'd4,
      OP_QUERY   = 3'd5
   } csq_op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_NO_CURRENT = 2'd2
   } csq_status_type;

   // one access of the entry store
   typedef struct packed {
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   rd_en;
      logic [IDX_W-1:0]       rd_addr;
   } csq_mem_req_type;

   // one finished result
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               has_current;
      logic [DATA_W-1:0]  current_value;
      logic [COUNT_W-1:0] item_count;
      logic [POS_W-1:0]   cursor_position;
   } csq_result_type;

endpackage

// ----- hdl/csq_if.sv -----
// request and response channel interfaces
interface csq_req_if;
   import csq_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DATA_W-1:0] new_value;

   modport source (output valid, output operation, output new_value, input ready);
   modport sink   (input valid, input operation, input new_value, output ready);
endinterface

interface csq_rsp_if;
   import csq_pkg::*;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic               has_current;
   logic [DATA_W-1:0]  current_value;
   logic [COUNT_W-1:0] item_count;
   logic [POS_W-1:0]   cursor_position;

   modport source (output valid, output status, output has_current, output current_value,
                   output item_count, output cursor_position, input ready);
   modport sink   (input valid, input status, input has_current, input current_value,
                   input item_count, input cursor_position, output ready);
endinterface

// ----- hdl/csq_store.sv -----
// entry store: one write port, one registered read port
module csq_store (
   input  logic                            clock,
   input  csq_pkg::csq_mem_req_type        mem_req,
   output logic [csq_pkg::VALUE_WIDTH-1:0] rd_data
);
   import csq_pkg::*;

   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/csq_ctrl.sv -----
// sequencer with the shared index step and compare unit
module csq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   csq_req_if.sink                         req,
   output csq_pkg::csq_mem_req_type        mem_req,
   input  logic [csq_pkg::VALUE_WIDTH-1:0] rd_data,
   output logic                            res_valid,
   output csq_pkg::csq_result_type         res_data,
   input  logic                            res_take
);
   import csq_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_SHIFT      = 7'b0000010,
      ST_SHIFT_WR   = 7'b0000100,
      ST_PUT        = 7'b0001000,
      ST_FETCH      = 7'b0010000,
      ST_FETCH_WAIT = 7'b0100000,
      ST_RESULT     = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       cursor_ff, cursor_in;
   logic                   cvalid_ff, cvalid_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   up_ff, up_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;

   logic                   accept;
   logic [CNT_W-1:0]       nb;
   logic [CNT_W-1:0]       cmp_a, cmp_b;
   logic                   more;
   logic [CNT_W-1:0]       cur_next;
   logic [CNT_W-1:0]       cnt_dec;
   logic                   full;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff >= CNT_W'(DEPTH));
   assign cur_next  = CNT_W'(cursor_ff) + CNT_W'(1);
   assign cnt_dec   = count_ff - CNT_W'(1);

   // shared unit: neighbor index and loop bound compare
   assign nb    = up_ff ? (CNT_W'(idx_ff) - CNT_W'(1)) : (CNT_W'(idx_ff) + CNT_W'(1));
   assign cmp_a = up_ff ? CNT_W'(pos_ff) : nb;
   assign cmp_b = up_ff ? CNT_W'(idx_ff) : count_ff;
   assign more  = (cmp_a < cmp_b);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      cvalid_in = cvalid_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      up_in     = up_ff;
      status_in = status_ff;
      val_in    = val_ff;
      value_in  = value_ff;
      mem_req   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               val_in    = VALUE_WIDTH'(req.new_value);
               state_in  = ST_FETCH;
               unique case (req.operation)
                  OP_START: begin
                     cursor_in = '0;
                     cvalid_in = (count_ff != '0);
                  end
                  OP_ADVANCE: begin
                     if (cvalid_ff) begin
                        if (cur_next >= count_ff) begin
                           cursor_in = '0;
                           cvalid_in = 1'b0;
                        end else begin
                           cursor_in = cur_next[IDX_W-1:0];
                        end
                     end
                  end
                  OP_INSERT, OP_ATTACH: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        // open a gap at the new position, shifting from the top down
                        if (req.operation == OP_INSERT) begin
                           pos_in = cvalid_ff ? cursor_ff : '0;
                        end else begin
                           pos_in = cvalid_ff ? cur_next[IDX_W-1:0] : count_ff[IDX_W-1:0];
                        end
                        cursor_in = pos_in;
                        cvalid_in = 1'b1;
                        idx_in    = count_ff[IDX_W-1:0];
                        up_in     = 1'b1;
                        state_in  = ST_SHIFT;
                     end
                  end
                  OP_REMOVE: begin
                     if (!cvalid_ff) begin
                        status_in = STAT_NO_CURRENT;
                     end else begin
                        idx_in   = cursor_ff;
                        up_in    = 1'b0;
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (more) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = nb[IDX_W-1:0];
               state_in        = ST_SHIFT_WR;
            end else if (up_ff) begin
               state_in = ST_PUT;
            end else begin
               count_in = cnt_dec;
               if (CNT_W'(cursor_ff) >= cnt_dec) begin
                  cursor_in = '0;
                  cvalid_in = 1'b0;
               end
               state_in = ST_FETCH;
            end
         end
         ST_SHIFT_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = rd_data;
            idx_in          = nb[IDX_W-1:0];
            state_in        = ST_SHIFT;
         end
         ST_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cursor_ff;
            mem_req.wr_data = val_ff;
            count_in        = count_ff + CNT_W'(1);
            value_in        = val_ff;
            state_in        = ST_RESULT;
         end
         ST_FETCH: begin
            if (cvalid_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cursor_ff;
               state_in        = ST_FETCH_WAIT;
            end else begin
               value_in = '0;
               state_in = ST_RESULT;
            end
         end
         ST_FETCH_WAIT: begin
            value_in = rd_data;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         cvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         cvalid_ff <= cvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      up_ff     <= up_in;
      status_ff <= status_in;
      val_ff    <= val_in;
      value_ff  <= value_in;
   end

   assign res_valid                = (state_ff == ST_RESULT);
   assign res_data.status          = status_ff;
   assign res_data.has_current     = cvalid_ff;
   assign res_data.current_value   = DATA_W'(value_ff);
   assign res_data.item_count      = COUNT_W'(count_ff);
   assign res_data.cursor_position = cvalid_ff ? POS_W'(cursor_ff) : '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("item count exceeds depth");

   a_cursor_parked: assert property (@(posedge clock) disable iff (reset)
      !cvalid_ff |-> (cursor_ff == '0))
      else $error("cursor not parked at zero without current item");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cvalid_ff) |-> (CNT_W'(cursor_ff) < count_ff))
      else $error("current item beyond list end");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("ready while transaction in progress");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESULT) |-> !mem_req.wr_en)
      else $error("store written outside an operation");

endmodule

// ----- hdl/cursor_sequence_store_core.sv -----
// cursor sequence store top level: sequencer, entry store and response register
// insert and attach shift the entries from the new position upward, remove shifts the entries
//   after the removed one down, one entry at a time since the shift loop shares one memory
//   port; the other operations go straight to fetching the current item
// throughput: one transaction at a time; the next request is taken once the result
//   has moved into the response register, which may still be waiting on its sink
// reset clears count, cursor and control state; entries are not cleared
module cursor_sequence_store_core (
   input  logic     clock,
   input  logic     reset,
   csq_req_if.sink  req_bus,
   csq_rsp_if.source rsp_bus
);
   import csq_pkg::*;

   csq_mem_req_type        mem_req;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   res_valid;
   csq_result_type         res_data;
   logic                   res_take;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   csq_result_type         rsp_data_ff, rsp_data_in;

   // sequencer and shared index unit
   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take)
   );

   // list entries
   csq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // result moves in when the register is empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_data_ff.status;
   assign rsp_bus.has_current     = rsp_data_ff.has_current;
   assign rsp_bus.current_value   = rsp_data_ff.current_value;
   assign rsp_bus.item_count      = rsp_data_ff.item_count;
   assign rsp_bus.cursor_position = rsp_data_ff.cursor_position;

endmodule

// ----- verif/tb_cursor_sequence_store_core.sv -----
// testbench for the cursor sequence store core: directed and random list operations
`timescale 1ns / 100ps

module tb_cursor_sequence_store_core;
   import csq_pkg::*;

   // unused operation codes, the block must treat them like a query
   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT  = 4000;
   // long hold-off of the response sink, well above the worst shift latency
   localparam int HOLDOFF_CYCLES = 300;
   // tail after the last result, covers the longest shift pass
   localparam int TAIL_CYCLES  = 80;
   localparam int RANDOM_ITEMS = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csq_req_if req_ch ();
   csq_rsp_if rsp_ch ();

   cursor_sequence_store_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the list, the cursor and the count
   logic [DATA_W-1:0] list_vals [DEPTH];
   int                list_len  = 0;
   int                cur_pos   = 0;
   bit                cur_valid = 1'b0;

   // results predicted at request acceptance, oldest first
   csq_result_type pending_results [$];

   int  mismatches = 0;
   bit  no_idle    = 1'b0;   // both sides run without gaps while set
   logic hold_rsp  = 1'b0;   // forces the response sink to hold off

   // make room at pos by moving pos..len-1 up by one
   function automatic void open_gap(int pos);
      for (int i = list_len; i > pos; i--) begin
         if (i < DEPTH) list_vals[i] = list_vals[i-1];
      end
   endfunction

   // apply one operation to the shadow list and return the result it should give
   function automatic csq_result_type predict_step(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
      csq_result_type r;
      csq_status_type st;
      st = STAT_OK;
      case (op)
         OP_START: begin
            cur_pos   = 0;
            cur_valid = (list_len > 0);
         end
         OP_ADVANCE: begin
            // without a current item nothing moves
            if (cur_valid) begin
               cur_pos++;
               if (cur_pos >= list_len) begin
                  cur_pos   = 0;
                  cur_valid = 1'b0;
               end
            end
         end
         OP_INSERT: begin
            if (list_len >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               // no current item means insert at the front
               if (!cur_valid) begin
                  cur_pos   = 0;
                  cur_valid = 1'b1;
               end
               open_gap(cur_pos);
               list_vals[cur_pos] = val;
               list_len++;
            end
         end
         OP_ATTACH: begin
            if (list_len >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               // no current item means append at the end
               if (cur_valid) begin
                  open_gap(cur_pos + 1);
                  cur_pos++;
               end else begin
                  cur_pos   = list_len;
                  cur_valid = 1'b1;
               end
               list_vals[cur_pos] = val;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (!cur_valid) begin
               st = STAT_NO_CURRENT;
            end else begin
               for (int i = cur_pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
               list_len--;
               // removing the tail item leaves no current item
               if (cur_pos >= list_len) begin
                  cur_pos   = 0;
                  cur_valid = 1'b0;
               end
            end
         end
         default: ;   // query and unused codes change nothing
      endcase
      r.status          = st;
      r.has_current     = cur_valid;
      r.current_value   = cur_valid ? list_vals[cur_pos] : '0;
      r.item_count      = list_len[COUNT_W-1:0];
      r.cursor_position = cur_valid ? cur_pos[POS_W-1:0] : '0;
      return r;
   endfunction

   // offer one request transaction, record the prediction once it is taken
   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.new_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(predict_step(op, val));
   endtask

   // sender pauses until every predicted result has come back
   task automatic idle_until_drained;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // cursor moves on an empty list, both ends, removal in the middle and at the tail
   task automatic test_cursor_edges;
      send_item(OP_QUERY,    '0);
      send_item(OP_START,    '0);            // start on empty list
      send_item(OP_ADVANCE,  '1);            // advance without current item
      send_item(OP_REMOVE,   '0);            // remove without current item
      send_item(OP_ATTACH,   '0);            // attach with no current goes to the end
      send_item(OP_ATTACH,   '1);
      send_item(OP_INSERT,   32'hA5A5_5A5A);
      send_item(OP_START,    '0);
      send_item(OP_ADVANCE,  '0);
      send_item(OP_ADVANCE,  '0);
      send_item(OP_ADVANCE,  '0);            // steps past the end
      send_item(OP_INSERT,   32'h8000_0001); // insert with no current goes to the front
      send_item(OP_ADVANCE,  '0);
      send_item(OP_REMOVE,   '1);            // middle item
      send_item(OP_ADVANCE,  '0);
      send_item(OP_REMOVE,   '0);            // tail item, cursor drops
      send_item(OP_REMOVE,   '0);
      send_item(OP_UNUSED_6, '1);
      send_item(OP_UNUSED_7, 32'h5555_AAAA);
      send_item(OP_QUERY,    32'hFFFF_0000);
   endtask

   // grow to the full depth, hit the full status, walk to the last slot, empty again
   task automatic test_fill_and_empty;
      while (list_len < DEPTH) send_item(OP_ATTACH, $urandom);
      send_item(OP_INSERT, '1);
      send_item(OP_ATTACH, '1);
      send_item(OP_START, '0);
      // insert at the head of a nearly full list shifts every entry
      send_item(OP_REMOVE, '0);
      send_item(OP_INSERT, $urandom);
      for (int i = 0; i < DEPTH - 1; i++) send_item(OP_ADVANCE, '0);
      send_item(OP_QUERY, '0);                 // cursor at the highest position
      send_item(OP_REMOVE, '0);
      send_item(OP_START, '0);
      while (list_len > 0) send_item(OP_REMOVE, '0);
      send_item(OP_REMOVE, '0);
      idle_until_drained();
   endtask

   // sink holds off for a long stretch while the source keeps offering
   task automatic test_sink_holdoff;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      no_idle = 1'b1;
      for (int i = 0; i < 12; i++) send_item((i % 3 == 2) ? OP_ADVANCE : OP_ATTACH, $urandom);
      no_idle = 1'b0;
      idle_until_drained();
   endtask

   // source goes quiet until the block has answered everything
   task automatic test_sender_pause;
      for (int i = 0; i < 6; i++) send_item(OP_INSERT, $urandom);
      idle_until_drained();
      for (int i = 0; i < 6; i++) send_item(i[0] ? OP_REMOVE : OP_START, $urandom);
      idle_until_drained();
   endtask

   // random operation mix, alternating between growing and shrinking the list
   task automatic test_random_sequences(input int n_items);
      int               done;
      int               roll;
      int               k;
      bit               growing;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] val;
      done    = 0;
      k       = 0;
      growing = 1'b1;
      while (done < n_items) begin
         if (k % 120 == 0) growing = $urandom_range(0, 1);
         // some stretches run back to back on both sides
         if (k % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 3)                         op = OP_START;
         else if (roll < 25)                   op = OP_ADVANCE;
         else if (roll < (growing ? 55 : 40))  op = OP_INSERT;
         else if (roll < (growing ? 85 : 55))  op = OP_ATTACH;
         else if (roll < 95)                   op = OP_REMOVE;
         else if (roll < 97)                   op = OP_QUERY;
         else                                  op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
         case ($urandom_range(0, 5))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom;
         endcase
         send_item(op, val);
         done++;
         k++;
      end
      no_idle = 1'b0;
   endtask

   // response sink: random stall per transaction, long hold-off when asked
   initial begin : rsp_sink
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         while (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // compare every response transaction with the oldest prediction
   always @(posedge clock) begin
      csq_result_type got;
      csq_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status          = rsp_ch.status;
         got.has_current     = rsp_ch.has_current;
         got.current_value   = rsp_ch.current_value;
         got.item_count      = rsp_ch.item_count;
         got.cursor_position = rsp_ch.cursor_position;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected result: status=%0d cur=%0b val=%h count=%0d pos=%0d",
                        $realtime, got.status, got.has_current, got.current_value,
                        got.item_count, got.cursor_position);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.has_current !== want.has_current ||
                got.current_value !== want.current_value ||
                got.item_count !== want.item_count ||
                got.cursor_position !== want.cursor_position) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t mismatch: exp status=%0d cur=%0b val=%h count=%0d pos=%0d",
                           $realtime, want.status, want.has_current, want.current_value,
                           want.item_count, want.cursor_position);
                  $display("%0t           got status=%0d cur=%0b val=%h count=%0d pos=%0d",
                           $realtime, got.status, got.has_current, got.current_value,
                           got.item_count, got.cursor_position);
               end
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb_cursor_sequence_store_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_QUERY;
      req_ch.new_value = '0;
      for (int i = 0; i < DEPTH; i++) list_vals[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cursor_edges();
      test_fill_and_empty();
      test_sink_holdoff();
      test_sender_pause();
      test_random_sequences(RANDOM_ITEMS);

      // all sent, let the last results come home
      idle_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_cursor_sequence_store_core: PASS");
      end else begin
         $display("tb_cursor_sequence_store_core: FAIL");
      end
      $finish;
   end

endmodule
